### design/lps_pkg.sv
// Shared constants, codes and state type of the LED pattern sequencer.
package lps_pkg;

  localparam int NUM_LEDS      = 8;
  localparam int TASK_SLOTS    = 16;
  localparam int PATTERN_DEPTH = 256;

  localparam int LED_W   = 3;
  localparam int ADDR_W  = 8;
  localparam int COLOR_W = 32;
  localparam int DELAY_W = 16;
  localparam int REP_W   = 16;
  localparam int STEP_W  = 8;
  localparam int CD_W    = 18;
  localparam int AGE_W   = 16;
  localparam int SLOT_W  = $clog2(TASK_SLOTS);
  localparam int PADDR_W = $clog2(PATTERN_DEPTH);

  localparam logic [COLOR_W-1:0] END_COLOR = 32'hFF00_0000;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic KIND_COLOR  = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_T_FIND,
    ST_T_RD0,
    ST_T_RD1,
    ST_T_CHK,
    ST_T_EMIT,
    ST_T_RES,
    ST_T_END,
    ST_S_CHK,
    ST_S_SUSP,
    ST_S_ALLOC,
    ST_S_REJ
  } state_e;

endpackage

### design/lps_if.sv
// Valid/ready channel interfaces for the sequencer's input items and results.
interface lps_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    op;
  logic [lps_pkg::LED_W-1:0]     led_id;
  logic [lps_pkg::ADDR_W-1:0]    entry_addr;
  logic [lps_pkg::COLOR_W-1:0]   color_value;
  logic [lps_pkg::DELAY_W-1:0]   delay_ticks;
  logic [lps_pkg::REP_W-1:0]     repeat_count;
  logic                          repeat_forever;

  modport source (output valid, op, led_id, entry_addr, color_value, delay_ticks,
                  repeat_count, repeat_forever, input ready);
  modport sink   (input valid, op, led_id, entry_addr, color_value, delay_ticks,
                  repeat_count, repeat_forever, output ready);
endinterface

interface lps_out_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [lps_pkg::LED_W-1:0]     out_led;
  logic [lps_pkg::COLOR_W-1:0]   out_color;
  logic                          last;

  modport source (output valid, kind, out_led, out_color, last, input ready);
  modport sink   (input valid, kind, out_led, out_color, last, output ready);
endinterface

### design/led_pattern_sequencer.sv
// LED pattern sequencer: task slots, pattern memory and the tick/start sequencer.
//
// Plays per-LED colour patterns from a 256-entry pattern memory through 16 task
// slots. For a start beat that is not rejected, the slot scanner visits every
// slot once to suspend the LED's running task. A tick visits each LED in turn;
// each firing task makes two reads through the single pattern memory read port,
// and for each task that finishes the same scanner looks for the oldest suspended
// task. A stalled output holds a tick or a rejected start. Results go out through
// an output register; the block takes no new beat until an item is done.
module led_pattern_sequencer (
  input  logic       clk_i,
  input  logic       rst_ni,
  lps_in_if.sink     in_i,
  lps_out_if.source  out_o
);

  localparam logic [lps_pkg::SLOT_W-1:0] LAST_SLOT = lps_pkg::SLOT_W'(lps_pkg::TASK_SLOTS - 1);
  localparam logic [lps_pkg::LED_W-1:0]  LAST_LED  = lps_pkg::LED_W'(lps_pkg::NUM_LEDS - 1);

  lps_pkg::state_e state_q, state_d;

  // slot state
  logic [lps_pkg::TASK_SLOTS-1:0] valid_q, valid_d, running_q, running_d, ticking_q, ticking_d;
  logic [lps_pkg::LED_W-1:0]   sled_q  [lps_pkg::TASK_SLOTS];
  logic [lps_pkg::LED_W-1:0]   sled_d  [lps_pkg::TASK_SLOTS];
  logic [lps_pkg::ADDR_W-1:0]  sbase_q [lps_pkg::TASK_SLOTS];
  logic [lps_pkg::ADDR_W-1:0]  sbase_d [lps_pkg::TASK_SLOTS];
  logic [lps_pkg::STEP_W-1:0]  sstep_q [lps_pkg::TASK_SLOTS];
  logic [lps_pkg::STEP_W-1:0]  sstep_d [lps_pkg::TASK_SLOTS];
  logic [lps_pkg::REP_W-1:0]   srep_q  [lps_pkg::TASK_SLOTS];
  logic [lps_pkg::REP_W-1:0]   srep_d  [lps_pkg::TASK_SLOTS];
  logic [lps_pkg::TASK_SLOTS-1:0] sendl_q, sendl_d;
  logic [lps_pkg::CD_W-1:0]    scd_q   [lps_pkg::TASK_SLOTS];
  logic [lps_pkg::CD_W-1:0]    scd_d   [lps_pkg::TASK_SLOTS];
  logic [lps_pkg::AGE_W-1:0]   sage_q  [lps_pkg::TASK_SLOTS];
  logic [lps_pkg::AGE_W-1:0]   sage_d  [lps_pkg::TASK_SLOTS];
  logic [lps_pkg::AGE_W-1:0]   age_cnt_q, age_cnt_d;

  // sequencer registers
  logic [lps_pkg::LED_W-1:0]   led_q, led_d;
  logic [lps_pkg::SLOT_W-1:0]  slot_q, slot_d, scan_q, scan_d, best_q, best_d;
  logic [lps_pkg::AGE_W-1:0]   best_age_q, best_age_d;
  logic                        best_ok_q, best_ok_d, done_q, done_d;
  logic [lps_pkg::COLOR_W-1:0] col_q, col_d;
  logic                        pend_q, pend_d;
  logic [lps_pkg::LED_W-1:0]   pend_led_q, pend_led_d;
  logic [lps_pkg::COLOR_W-1:0] pend_col_q, pend_col_d;
  logic [lps_pkg::LED_W-1:0]   in_led_q, in_led_d;
  logic [lps_pkg::ADDR_W-1:0]  in_addr_q, in_addr_d;
  logic [lps_pkg::REP_W-1:0]   in_rep_q, in_rep_d;
  logic                        in_forever_q, in_forever_d;

  // output register
  logic                        ov_q, ov_d, ok_q, ok_d, olast_q, olast_d;
  logic [lps_pkg::LED_W-1:0]   oled_q, oled_d;
  logic [lps_pkg::COLOR_W-1:0] ocol_q, ocol_d;

  // pattern memory
  logic [lps_pkg::COLOR_W-1:0] mem_col [lps_pkg::PATTERN_DEPTH];
  logic [lps_pkg::DELAY_W-1:0] mem_dly [lps_pkg::PATTERN_DEPTH];
  logic [lps_pkg::COLOR_W-1:0] rd_col_q;
  logic [lps_pkg::DELAY_W-1:0] rd_dly_q;
  logic [lps_pkg::PADDR_W-1:0] raddr;
  logic                        wen;

  logic                        accept, out_free, hit, free_ok;
  logic [lps_pkg::SLOT_W-1:0]  hit_slot, free_slot;
  logic [lps_pkg::AGE_W-1:0]   scan_age;

  assign accept   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == lps_pkg::ST_IDLE);
  assign out_free = !ov_q || out_o.ready;
  assign wen      = accept && (in_i.op == lps_pkg::OP_WRITE);
  assign scan_age = age_cnt_q - sage_q[scan_q];

  assign out_o.valid     = ov_q;
  assign out_o.kind      = ok_q;
  assign out_o.out_led   = oled_q;
  assign out_o.out_color = ocol_q;
  assign out_o.last      = olast_q;

  // lowest ticking slot of the current LED, lowest free slot
  always_comb begin
    hit = 1'b0;
    hit_slot = '0;
    free_ok = 1'b0;
    free_slot = '0;
    for (int i = lps_pkg::TASK_SLOTS - 1; i >= 0; i--) begin
      if (ticking_q[i] && valid_q[i] && sled_q[i] == led_q) begin
        hit = 1'b1;
        hit_slot = lps_pkg::SLOT_W'(i);
      end
      if (!valid_q[i]) begin
        free_ok = 1'b1;
        free_slot = lps_pkg::SLOT_W'(i);
      end
    end
  end

  always_comb begin
    raddr = sbase_q[slot_q] + sstep_q[slot_q];
    if (state_q == lps_pkg::ST_T_RD1) begin
      raddr = sbase_q[slot_q] + sstep_q[slot_q] + lps_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wen) begin
      mem_col[in_i.entry_addr] <= in_i.color_value;
      mem_dly[in_i.entry_addr] <= in_i.delay_ticks;
    end
    rd_col_q <= mem_col[raddr];
    rd_dly_q <= mem_dly[raddr];
  end

  always_comb begin
    state_d = state_q;
    valid_d = valid_q;
    running_d = running_q;
    ticking_d = ticking_q;
    sled_d = sled_q;
    sbase_d = sbase_q;
    sstep_d = sstep_q;
    srep_d = srep_q;
    sendl_d = sendl_q;
    scd_d = scd_q;
    sage_d = sage_q;
    age_cnt_d = age_cnt_q;
    led_d = led_q;
    slot_d = slot_q;
    scan_d = scan_q;
    best_d = best_q;
    best_age_d = best_age_q;
    best_ok_d = best_ok_q;
    done_d = done_q;
    col_d = col_q;
    pend_d = pend_q;
    pend_led_d = pend_led_q;
    pend_col_d = pend_col_q;
    in_led_d = in_led_q;
    in_addr_d = in_addr_q;
    in_rep_d = in_rep_q;
    in_forever_d = in_forever_q;
    ov_d = ov_q && !out_o.ready;
    ok_d = ok_q;
    olast_d = olast_q;
    oled_d = oled_q;
    ocol_d = ocol_q;

    unique case (state_q)
      lps_pkg::ST_IDLE: begin
        if (accept) begin
          in_led_d = in_i.led_id;
          in_addr_d = in_i.entry_addr;
          in_rep_d = in_i.repeat_count;
          in_forever_d = in_i.repeat_forever;
          case (in_i.op)
            lps_pkg::OP_TICK: begin
              ticking_d = running_q;
              led_d = '0;
              pend_d = 1'b0;
              state_d = lps_pkg::ST_T_FIND;
            end
            lps_pkg::OP_START: state_d = lps_pkg::ST_S_CHK;
            default: ;
          endcase
        end
      end

      lps_pkg::ST_T_FIND: begin
        if (hit && scd_q[hit_slot] <= lps_pkg::CD_W'(1)) begin
          slot_d = hit_slot;
          state_d = lps_pkg::ST_T_RD0;
        end else begin
          if (hit) scd_d[hit_slot] = scd_q[hit_slot] - lps_pkg::CD_W'(1);
          if (led_q == LAST_LED) state_d = lps_pkg::ST_T_END;
          else led_d = led_q + lps_pkg::LED_W'(1);
        end
      end

      lps_pkg::ST_T_RD0: state_d = lps_pkg::ST_T_RD1;

      lps_pkg::ST_T_RD1: begin
        // current entry: colour out, reload countdown, advance
        col_d = rd_col_q;
        scd_d[slot_q] = lps_pkg::CD_W'(rd_dly_q);
        sstep_d[slot_q] = sstep_q[slot_q] + lps_pkg::STEP_W'(1);
        state_d = lps_pkg::ST_T_CHK;
      end

      lps_pkg::ST_T_CHK: begin
        done_d = 1'b0;
        if (rd_col_q == lps_pkg::END_COLOR && rd_dly_q == '0) begin
          sstep_d[slot_q] = '0;
          if (!sendl_q[slot_q]) begin
            srep_d[slot_q] = srep_q[slot_q] - lps_pkg::REP_W'(1);
            if (srep_q[slot_q] == lps_pkg::REP_W'(1)) begin
              done_d = 1'b1;
              valid_d[slot_q] = 1'b0;
              running_d[slot_q] = 1'b0;
            end
          end
        end
        state_d = lps_pkg::ST_T_EMIT;
      end

      lps_pkg::ST_T_EMIT: begin
        // hold one result back so the final one of the tick can carry last
        if (!pend_q || out_free) begin
          if (pend_q) begin
            ov_d = 1'b1;
            ok_d = lps_pkg::KIND_COLOR;
            oled_d = pend_led_q;
            ocol_d = pend_col_q;
            olast_d = 1'b0;
          end
          pend_d = 1'b1;
          pend_led_d = led_q;
          pend_col_d = col_q;
          if (done_q) begin
            scan_d = '0;
            best_ok_d = 1'b0;
            state_d = lps_pkg::ST_T_RES;
          end else if (led_q == LAST_LED) begin
            state_d = lps_pkg::ST_T_END;
          end else begin
            led_d = led_q + lps_pkg::LED_W'(1);
            state_d = lps_pkg::ST_T_FIND;
          end
        end
      end

      lps_pkg::ST_T_RES: begin
        logic cand;
        logic take;
        cand = valid_q[scan_q] && !running_q[scan_q] && sled_q[scan_q] == led_q;
        take = cand && (!best_ok_q || scan_age > best_age_q);
        if (take) begin
          best_d = scan_q;
          best_age_d = scan_age;
          best_ok_d = 1'b1;
        end
        if (scan_q == LAST_SLOT) begin
          if (take) running_d[scan_q] = 1'b1;
          else if (best_ok_q) running_d[best_q] = 1'b1;
          if (led_q == LAST_LED) begin
            state_d = lps_pkg::ST_T_END;
          end else begin
            led_d = led_q + lps_pkg::LED_W'(1);
            state_d = lps_pkg::ST_T_FIND;
          end
        end else begin
          scan_d = scan_q + lps_pkg::SLOT_W'(1);
        end
      end

      lps_pkg::ST_T_END: begin
        if (!pend_q) begin
          state_d = lps_pkg::ST_IDLE;
        end else if (out_free) begin
          ov_d = 1'b1;
          ok_d = lps_pkg::KIND_COLOR;
          oled_d = pend_led_q;
          ocol_d = pend_col_q;
          olast_d = 1'b1;
          pend_d = 1'b0;
          state_d = lps_pkg::ST_IDLE;
        end
      end

      lps_pkg::ST_S_CHK: begin
        if (!free_ok || 32'(in_led_q) >= lps_pkg::NUM_LEDS) begin
          state_d = lps_pkg::ST_S_REJ;
        end else begin
          slot_d = free_slot;
          scan_d = '0;
          state_d = lps_pkg::ST_S_SUSP;
        end
      end

      lps_pkg::ST_S_SUSP: begin
        if (valid_q[scan_q] && running_q[scan_q] && sled_q[scan_q] == in_led_q) begin
          running_d[scan_q] = 1'b0;
          sage_d[scan_q] = age_cnt_q;
          age_cnt_d = age_cnt_q + lps_pkg::AGE_W'(1);
        end
        if (scan_q == LAST_SLOT) state_d = lps_pkg::ST_S_ALLOC;
        else scan_d = scan_q + lps_pkg::SLOT_W'(1);
      end

      lps_pkg::ST_S_ALLOC: begin
        valid_d[slot_q] = 1'b1;
        running_d[slot_q] = 1'b1;
        sled_d[slot_q] = in_led_q;
        sbase_d[slot_q] = in_addr_q;
        sstep_d[slot_q] = '0;
        srep_d[slot_q] = (in_rep_q == '0) ? lps_pkg::REP_W'(1) : in_rep_q;
        sendl_d[slot_q] = in_forever_q;
        scd_d[slot_q] = '0;
        sage_d[slot_q] = '0;
        state_d = lps_pkg::ST_IDLE;
      end

      lps_pkg::ST_S_REJ: begin
        if (out_free) begin
          ov_d = 1'b1;
          ok_d = lps_pkg::KIND_REJECT;
          oled_d = in_led_q;
          ocol_d = '0;
          olast_d = 1'b1;
          state_d = lps_pkg::ST_IDLE;
        end
      end

      default: state_d = lps_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lps_pkg::ST_IDLE;
      valid_q <= '0;
      running_q <= '0;
      age_cnt_q <= '0;
      pend_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      running_q <= running_d;
      age_cnt_q <= age_cnt_d;
      pend_q <= pend_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ticking_q <= ticking_d;
    sled_q <= sled_d;
    sbase_q <= sbase_d;
    sstep_q <= sstep_d;
    srep_q <= srep_d;
    sendl_q <= sendl_d;
    scd_q <= scd_d;
    sage_q <= sage_d;
    led_q <= led_d;
    slot_q <= slot_d;
    scan_q <= scan_d;
    best_q <= best_d;
    best_age_q <= best_age_d;
    best_ok_q <= best_ok_d;
    done_q <= done_d;
    col_q <= col_d;
    pend_led_q <= pend_led_d;
    pend_col_q <= pend_col_d;
    in_led_q <= in_led_d;
    in_addr_q <= in_addr_d;
    in_rep_q <= in_rep_d;
    in_forever_q <= in_forever_d;
    ok_q <= ok_d;
    olast_q <= olast_d;
    oled_q <= oled_d;
    ocol_q <= ocol_d;
  end

endmodule

### dv/tb_led_pattern_sequencer.sv
// Testbench for the LED pattern sequencer: directed and random beats checked against a predictor.
`timescale 1ns / 100ps

module tb_led_pattern_sequencer;

  logic clk_i;
  logic rst_ni;

  lps_in_if  in_if ();
  lps_out_if out_if ();

  led_pattern_sequencer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  typedef struct packed {
    logic       kind;
    logic [2:0] led;
    logic [31:0] color;
    logic       last;
  } led_update_t;

  // predictor state
  logic [31:0] pat_color [lps_pkg::PATTERN_DEPTH];
  logic [15:0] pat_delay [lps_pkg::PATTERN_DEPTH];
  bit          pat_known [lps_pkg::PATTERN_DEPTH];
  bit          sv [lps_pkg::TASK_SLOTS];
  bit          sr [lps_pkg::TASK_SLOTS];
  logic [2:0]  sled [lps_pkg::TASK_SLOTS];
  logic [7:0]  sbase [lps_pkg::TASK_SLOTS];
  logic [7:0]  sstep [lps_pkg::TASK_SLOTS];
  logic [15:0] srep [lps_pkg::TASK_SLOTS];
  bit          send [lps_pkg::TASK_SLOTS];
  logic [17:0] scd [lps_pkg::TASK_SLOTS];
  logic [15:0] sage [lps_pkg::TASK_SLOTS];
  logic [15:0] age_cnt;

  led_update_t update_q[$];
  int  errors;
  bit  hold_off;
  longint cycles;

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result checker and random stall of the receiver
  always @(posedge clk_i) begin
    led_update_t got, exp_u;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{out_if.kind, out_if.out_led, out_if.out_color, out_if.last};
      if (update_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        exp_u = update_q.pop_front();
        if (got !== exp_u) begin
          $display("%0t: mismatch expected %h actual %h", $time, exp_u, got);
          errors++;
        end
      end
    end
    if (hold_off) out_if.ready <= 1'b0;
    else out_if.ready <= ($urandom_range(0, 3) != 0);
  end

  function automatic logic [7:0] slot_addr(int s);
    return sbase[s] + sstep[s];
  endfunction

  function automatic void resume_oldest(logic [2:0] led);
    int best;
    logic [15:0] best_age, a;
    best = -1;
    best_age = 0;
    for (int s = 0; s < lps_pkg::TASK_SLOTS; s++) begin
      if (sv[s] && !sr[s] && sled[s] == led) begin
        a = age_cnt - sage[s];
        if (best < 0 || a > best_age) begin
          best = s;
          best_age = a;
        end
      end
    end
    if (best >= 0) sr[best] = 1'b1;
  endfunction

  function automatic void predict_updates(logic [1:0] op, logic [2:0] led, logic [7:0] addr,
                                          logic [31:0] color, logic [15:0] dly,
                                          logic [15:0] rep, logic forever_f);
    bit ticking [lps_pkg::TASK_SLOTS];
    led_update_t res[$];
    int f, s;
    logic [7:0] a, n;
    bit done;
    if (op == lps_pkg::OP_WRITE) begin
      pat_color[addr] = color;
      pat_delay[addr] = dly;
      pat_known[addr] = 1'b1;
    end else if (op == lps_pkg::OP_START) begin
      f = -1;
      for (s = 0; s < lps_pkg::TASK_SLOTS; s++) if (!sv[s] && f < 0) f = s;
      if (f < 0) begin
        res.push_back('{lps_pkg::KIND_REJECT, led, 32'd0, 1'b0});
      end else begin
        for (s = 0; s < lps_pkg::TASK_SLOTS; s++) begin
          if (sv[s] && sr[s] && sled[s] == led) begin
            sr[s] = 1'b0;
            sage[s] = age_cnt;
            age_cnt++;
          end
        end
        sv[f] = 1; sr[f] = 1; sled[f] = led; sbase[f] = addr; sstep[f] = 0;
        srep[f] = (rep == 0) ? 16'd1 : rep;
        send[f] = forever_f; scd[f] = 0; sage[f] = 0;
      end
    end else if (op == lps_pkg::OP_TICK) begin
      for (s = 0; s < lps_pkg::TASK_SLOTS; s++) ticking[s] = sr[s];
      for (int l = 0; l < lps_pkg::NUM_LEDS; l++) begin
        for (s = 0; s < lps_pkg::TASK_SLOTS; s++) if (ticking[s] && sv[s] && sled[s] == l) break;
        if (s < lps_pkg::TASK_SLOTS) begin
          if (scd[s] <= 1) begin
            done = 0;
            a = slot_addr(s);
            res.push_back('{lps_pkg::KIND_COLOR, 3'(l), pat_color[a], 1'b0});
            scd[s] = 18'(pat_delay[a]);
            sstep[s]++;
            n = slot_addr(s);
            if (pat_color[n] == lps_pkg::END_COLOR && pat_delay[n] == 0) begin
              sstep[s] = 0;
              if (!send[s]) begin
                srep[s]--;
                if (srep[s] == 0) done = 1;
              end
            end
            if (done) begin
              sv[s] = 0; sr[s] = 0;
              resume_oldest(3'(l));
            end
          end else begin
            scd[s]--;
          end
        end
      end
    end
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
    foreach (res[i]) update_q.push_back(res[i]);
  endfunction

  task automatic send_beat(logic [1:0] op, logic [2:0] led, logic [7:0] addr,
                           logic [31:0] color, logic [15:0] dly, logic [15:0] rep,
                           logic forever_f);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    // drop valid only across a gap; with no gap the next beat follows directly
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.op             <= op;
    in_if.led_id         <= led;
    in_if.entry_addr     <= addr;
    in_if.color_value    <= color;
    in_if.delay_ticks    <= dly;
    in_if.repeat_count   <= rep;
    in_if.repeat_forever <= forever_f;
    predict_updates(op, led, addr, color, dly, rep, forever_f);
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic wr(logic [7:0] addr, logic [31:0] color, logic [15:0] dly);
    send_beat(lps_pkg::OP_WRITE, 3'($urandom), addr, color, dly, 16'($urandom), 1'($urandom));
  endtask

  task automatic tick();
    send_beat(lps_pkg::OP_TICK, 3'($urandom), 8'($urandom), $urandom, 16'($urandom),
              16'($urandom), 1'($urandom));
  endtask

  task automatic start(logic [2:0] led, logic [7:0] base, logic [15:0] rep, logic fv);
    send_beat(lps_pkg::OP_START, led, base, $urandom, 16'($urandom), rep, fv);
  endtask

  // a start whose pattern walks only through known entries
  function automatic bit base_is_safe(logic [7:0] base);
    for (int i = 0; i < 256; i++) begin
      logic [7:0] ad;
      ad = base + 8'(i);
      if (!pat_known[ad]) return 0;
      if (i > 0 && pat_color[ad] == lps_pkg::END_COLOR && pat_delay[ad] == 0) return 1;
    end
    return 1;
  endfunction

  task automatic drain();
    in_if.valid <= 1'b0;
    while (update_q.size() != 0) @(posedge clk_i);
    repeat (500) @(posedge clk_i);
  endtask

  task automatic test_directed();
    // patterns: base 0 two entries, base 8 terminator first, extremes of colour and delay
    wr(8'd0, 32'h0000_0000, 16'd0);
    wr(8'd1, 32'hFFFF_FFFF, 16'd2);
    wr(8'd2, lps_pkg::END_COLOR, 16'd0);
    wr(8'd8, lps_pkg::END_COLOR, 16'd0);
    wr(8'd9, 32'h1234_5678, 16'hFFFF);
    wr(8'd10, lps_pkg::END_COLOR, 16'd0);
    wr(8'd254, 32'hA5A5_A5A5, 16'd1);
    wr(8'd255, 32'h5A5A_5A5A, 16'd0);
    start(3'd0, 8'd0, 16'd0, 1'b0);
    start(3'd7, 8'd8, 16'd2, 1'b0);
    start(3'd3, 8'd254, 16'hFFFF, 1'b1);
    tick(); tick(); tick();
    start(3'd0, 8'd9, 16'd1, 1'b0);
    repeat (6) tick();
    send_beat(lps_pkg::OP_NOP, 3'd5, 8'd1, $urandom, 16'hFFFF, 16'hFFFF, 1'b1);
    tick();
    drain();
  endtask

  task automatic test_full_slots();
    // fill every slot, then the further starts are rejected
    for (int i = 0; i < lps_pkg::TASK_SLOTS + 2; i++) start(3'(i), 8'd0, 16'd1, 1'b0);
    tick();
    drain();
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk_i);
        hold_off = 0;
      end
      repeat (10) tick();
    join
    drain();
  endtask

  task automatic test_random(int n);
    logic [7:0] b;
    int r, k;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        // contiguous block ending in a terminator
        b = 8'($urandom_range(0, 5) * 40);
        k = $urandom_range(1, 4);
        for (int j = 0; j < k; j++)
          wr(b + 8'(j), $urandom, 16'($urandom_range(0, 3)));
        wr(b + 8'(k), lps_pkg::END_COLOR, 16'd0);
      end else if (r < 20) begin
        // fill only unwritten entries so no running walk changes
        b = 8'($urandom);
        if (!pat_known[b])
          wr(b, ($urandom_range(0, 1)) ? lps_pkg::END_COLOR : $urandom,
             ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2)));
        else tick();
      end else if (r < 40) begin
        b = 8'($urandom);
        if (base_is_safe(b))
          start(3'($urandom), b, 16'($urandom_range(0, 3)), ($urandom_range(0, 7) == 0));
        else tick();
      end else if (r < 42) begin
        send_beat(lps_pkg::OP_NOP, 3'($urandom), 8'($urandom), $urandom, 16'($urandom),
                  16'($urandom), 1'($urandom));
      end else begin
        tick();
      end
    end
    drain();
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    hold_off = 0;
    age_cnt = 0;
    for (int i = 0; i < lps_pkg::TASK_SLOTS; i++) begin
      sv[i] = 0; sr[i] = 0;
    end
    for (int i = 0; i < lps_pkg::PATTERN_DEPTH; i++) pat_known[i] = 0;
    in_if.valid = 0; in_if.op = lps_pkg::OP_TICK; in_if.led_id = 0; in_if.entry_addr = 0;
    in_if.color_value = 0; in_if.delay_ticks = 0; in_if.repeat_count = 0;
    in_if.repeat_forever = 0;
    out_if.ready = 0;
    rst_ni = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_slots();
    // the ticks under backpressure also run the finite tasks dry and free their slots
    test_backpressure();
    test_random(240);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### led_pattern_sequencer.f
design/lps_pkg.sv
design/lps_if.sv
design/led_pattern_sequencer.sv
dv/tb_led_pattern_sequencer.sv
